FILE: rtl/core/aelv_pkg.sv
// ----------------------------------------------------------------------------
// aelv_pkg
// Shared types and codes for the ACL entry list validator.
// ----------------------------------------------------------------------------
package aelv_pkg;

   localparam int unsigned TYPE_BITS       = 8;
   localparam int unsigned PERM_BITS       = 8;
   localparam int unsigned ENTRY_ID_BITS   = 32;
   localparam int unsigned STATUS_BITS     = 3;
   localparam int unsigned CNT_BITS        = 2;
   localparam int unsigned ID_BITS_DEFAULT = 32;

   // Entry kinds, low bits of the type code
   localparam logic [TYPE_BITS-1:0] KIND_USER_OBJ  = 8'd1;
   localparam logic [TYPE_BITS-1:0] KIND_USER      = 8'd2;
   localparam logic [TYPE_BITS-1:0] KIND_GROUP_OBJ = 8'd3;
   localparam logic [TYPE_BITS-1:0] KIND_GROUP     = 8'd4;
   localparam logic [TYPE_BITS-1:0] KIND_MASK      = 8'd5;
   localparam logic [TYPE_BITS-1:0] KIND_OTHER     = 8'd6;
   localparam logic [TYPE_BITS-1:0] TYPE_DEFAULT   = 8'h20;
   localparam logic [TYPE_BITS-1:0] KIND_KEEP_MASK = 8'hDF;

   localparam logic [PERM_BITS-1:0] PERM_MAX = 8'd7;

   // Status codes
   localparam logic [STATUS_BITS-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_BAD_TYPE    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_BAD_PERM    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_DUPLICATE   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_OBJ_COUNT   = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_MASK_MISS   = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_DEF_OBJECTS = 3'd6;
   localparam logic [STATUS_BITS-1:0] ST_DEF_MASK    = 3'd7;

   localparam logic [CNT_BITS-1:0] CNT_ONE = 2'd1;
   localparam logic [CNT_BITS-1:0] CNT_SAT = 2'd2;

   // Per-list tally, everything but the previous id
   typedef struct packed {
      logic [CNT_BITS-1:0]    cnt_user_obj;
      logic [CNT_BITS-1:0]    cnt_group_obj;
      logic [CNT_BITS-1:0]    cnt_other;
      logic [CNT_BITS-1:0]    cnt_mask;
      logic [CNT_BITS-1:0]    cnt_def_user_obj;
      logic [CNT_BITS-1:0]    cnt_def_group_obj;
      logic [CNT_BITS-1:0]    cnt_def_other;
      logic [CNT_BITS-1:0]    cnt_def_mask;
      logic                   seen_user;
      logic                   seen_group;
      logic                   seen_default;
      logic                   seen_def_user;
      logic                   seen_def_group;
      logic [TYPE_BITS-1:0]   prev_type;
      logic                   first_pending;
      logic [STATUS_BITS-1:0] error_code;
   } tally_type;

   localparam tally_type TALLY_RESET = '{
      cnt_user_obj:      '0,
      cnt_group_obj:     '0,
      cnt_other:         '0,
      cnt_mask:          '0,
      cnt_def_user_obj:  '0,
      cnt_def_group_obj: '0,
      cnt_def_other:     '0,
      cnt_def_mask:      '0,
      seen_user:         1'b0,
      seen_group:        1'b0,
      seen_default:      1'b0,
      seen_def_user:     1'b0,
      seen_def_group:    1'b0,
      prev_type:         '0,
      first_pending:     1'b1,
      error_code:        ST_OK
   };

   function automatic logic [CNT_BITS-1:0] bump(input logic [CNT_BITS-1:0] c);
      return (c >= CNT_SAT) ? CNT_SAT : c + CNT_ONE;
   endfunction

endpackage

FILE: rtl/core/aelv_req_if.sv
// ----------------------------------------------------------------------------
// aelv_req_if
// Request channel: one ACL entry per request.
// ----------------------------------------------------------------------------
interface aelv_req_if;
   import aelv_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [TYPE_BITS-1:0]     entry_type;
   logic [PERM_BITS-1:0]     entry_perm;
   logic [ENTRY_ID_BITS-1:0] entry_id;
   logic                     last_entry;

   modport source (output valid, entry_type, entry_perm, entry_id, last_entry,
                   input ready);
   modport sink   (input valid, entry_type, entry_perm, entry_id, last_entry,
                   output ready);
endinterface

FILE: rtl/core/aelv_rsp_if.sv
// ----------------------------------------------------------------------------
// aelv_rsp_if
// Response channel: running status and final verdict.
// ----------------------------------------------------------------------------
interface aelv_rsp_if;
   import aelv_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic                   list_done;

   modport source (output valid, status, list_done, input ready);
   modport sink   (input valid, status, list_done, output ready);
endinterface

FILE: rtl/core/acl_entry_list_validator.sv
// ----------------------------------------------------------------------------
// acl_entry_list_validator
// Streaming validity check of a POSIX-style ACL, one entry per request.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one ACL entry per request (type, permission, id, last mark).
//   rsp returns exactly one response per request: the sticky first-error
//   code with list_done low, or on the last entry the final verdict for the
//   whole list with list_done high. The tally then clears for the next list.
//   A request passes through the input register, then the response register.
//   Throughput: one request per cycle while rsp does not stall; the per-entry
//   decode, counter update and one id compare sit between the input and
//   response registers.
//   Reset (synchronous, active high) empties both stages and sets the tally
//   to the start of a new list.
//   When rsp stalls, the response register holds; the input register still
//   takes one more request, then req.ready drops until rsp drains.
// ----------------------------------------------------------------------------
module acl_entry_list_validator #(
   parameter int unsigned ID_BITS = aelv_pkg::ID_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   aelv_req_if.sink   req,
   aelv_rsp_if.source rsp
);
   import aelv_pkg::*;

   localparam int unsigned KEEP_BITS = (ID_BITS < ENTRY_ID_BITS) ? ID_BITS : ENTRY_ID_BITS;

   // Input stage
   logic                     s1_valid_ff, s1_valid_in;
   logic [TYPE_BITS-1:0]     s1_type_ff;
   logic [PERM_BITS-1:0]     s1_perm_ff;
   logic [ENTRY_ID_BITS-1:0] s1_id_ff;
   logic                     s1_last_ff;

   // List tally
   tally_type                tally_ff, tally_in;
   logic [KEEP_BITS-1:0]     prev_id_ff, prev_id_in;

   // Response stage
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic                     advance;
   logic                     req_take;

   // Advance the input stage whenever the response register is free or draining
   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req_take = req.valid && req.ready;
   assign req.ready = !s1_valid_ff || advance;

   aelv_entry_check #(
      .ID_BITS (ID_BITS)
   ) u_check (
      .tally      (tally_ff),
      .prev_id    (prev_id_ff),
      .entry_type (s1_type_ff),
      .entry_perm (s1_perm_ff),
      .entry_id   (s1_id_ff),
      .last_entry (s1_last_ff),
      .tally_next (tally_in),
      .id_kept    (prev_id_in),
      .status     (rsp_status_in),
      .list_done  (rsp_done_in)
   );

   // Hold the input stage unless it advances or a new request lands
   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tally_ff     <= TALLY_RESET;
         prev_id_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            tally_ff   <= tally_in;
            prev_id_ff <= prev_id_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_type_ff <= req.entry_type;
         s1_perm_ff <= req.entry_perm;
         s1_id_ff   <= req.entry_id;
         s1_last_ff <= req.last_entry;
      end
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_done_ff   <= rsp_done_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.list_done = rsp_done_ff;

endmodule

FILE: rtl/core/aelv_entry_check.sv
// ----------------------------------------------------------------------------
// aelv_entry_check
// Per-entry checks, tally update and end-of-list verdict.
// ----------------------------------------------------------------------------
module aelv_entry_check #(
   parameter int unsigned ID_BITS = aelv_pkg::ID_BITS_DEFAULT
) (
   input  aelv_pkg::tally_type                    tally,
   input  logic [(ID_BITS < 32 ? ID_BITS : 32)-1:0] prev_id,
   input  logic [aelv_pkg::TYPE_BITS-1:0]         entry_type,
   input  logic [aelv_pkg::PERM_BITS-1:0]         entry_perm,
   input  logic [aelv_pkg::ENTRY_ID_BITS-1:0]     entry_id,
   input  logic                                   last_entry,
   output aelv_pkg::tally_type                    tally_next,
   output logic [(ID_BITS < 32 ? ID_BITS : 32)-1:0] id_kept,
   output logic [aelv_pkg::STATUS_BITS-1:0]       status,
   output logic                                   list_done
);
   import aelv_pkg::*;

   localparam int unsigned KEEP_BITS = (ID_BITS < ENTRY_ID_BITS) ? ID_BITS : ENTRY_ID_BITS;

   logic [TYPE_BITS-1:0]   kind;
   logic                   is_def;
   logic                   known;
   logic [STATUS_BITS-1:0] entry_err;
   logic [STATUS_BITS-1:0] verdict;
   tally_type              upd;

   assign id_kept = entry_id[KEEP_BITS-1:0];
   assign kind    = entry_type & KIND_KEEP_MASK;
   assign is_def  = |(entry_type & TYPE_DEFAULT);
   assign known   = (kind >= KIND_USER_OBJ) && (kind <= KIND_OTHER);

   // Type first, then permission, then duplicate of previous entry
   always_comb begin
      if (!known) begin
         entry_err = ST_BAD_TYPE;
      end else if (entry_perm > PERM_MAX) begin
         entry_err = ST_BAD_PERM;
      end else if (!tally.first_pending && (entry_type == tally.prev_type) &&
                   (id_kept == prev_id)) begin
         entry_err = ST_DUPLICATE;
      end else begin
         entry_err = ST_OK;
      end
   end

   always_comb begin
      upd = tally;
      if (known) begin
         if (is_def) begin
            upd.seen_default = 1'b1;
         end
         case (kind)
            KIND_USER_OBJ: begin
               if (is_def) upd.cnt_def_user_obj = bump(tally.cnt_def_user_obj);
               else        upd.cnt_user_obj     = bump(tally.cnt_user_obj);
            end
            KIND_USER: begin
               if (is_def) upd.seen_def_user = 1'b1;
               else        upd.seen_user     = 1'b1;
            end
            KIND_GROUP_OBJ: begin
               if (is_def) upd.cnt_def_group_obj = bump(tally.cnt_def_group_obj);
               else        upd.cnt_group_obj     = bump(tally.cnt_group_obj);
            end
            KIND_GROUP: begin
               if (is_def) upd.seen_def_group = 1'b1;
               else        upd.seen_group     = 1'b1;
            end
            KIND_MASK: begin
               if (is_def) upd.cnt_def_mask = bump(tally.cnt_def_mask);
               else        upd.cnt_mask     = bump(tally.cnt_mask);
            end
            default: begin
               if (is_def) upd.cnt_def_other = bump(tally.cnt_def_other);
               else        upd.cnt_other     = bump(tally.cnt_other);
            end
         endcase
      end
      upd.prev_type     = entry_type;
      upd.first_pending = 1'b0;
      if (tally.error_code == ST_OK) begin
         upd.error_code = entry_err;
      end
   end

   // Cardinality rules on the updated tally
   always_comb begin
      if (upd.error_code != ST_OK) begin
         verdict = upd.error_code;
      end else if (upd.cnt_user_obj != CNT_ONE || upd.cnt_group_obj != CNT_ONE ||
                   upd.cnt_other != CNT_ONE) begin
         verdict = ST_OBJ_COUNT;
      end else if ((upd.seen_user || upd.seen_group) && upd.cnt_mask != CNT_ONE) begin
         verdict = ST_MASK_MISS;
      end else if (upd.seen_default &&
                   (upd.cnt_def_user_obj != CNT_ONE || upd.cnt_def_group_obj != CNT_ONE ||
                    upd.cnt_def_other != CNT_ONE)) begin
         verdict = ST_DEF_OBJECTS;
      end else if ((upd.seen_def_user || upd.seen_def_group) &&
                   upd.cnt_def_mask != CNT_ONE) begin
         verdict = ST_DEF_MASK;
      end else begin
         verdict = ST_OK;
      end
   end

   assign tally_next = last_entry ? TALLY_RESET : upd;
   assign status     = last_entry ? verdict : upd.error_code;
   assign list_done  = last_entry;

endmodule
